// File: rtl/core/adl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adl_pkg
// Shared constants, register indexes and the command record for the audio
// delay line with crossfade.
// ----------------------------------------------------------------------------
package adl_pkg;

    localparam int RING_FRAMES_DEF    = 16384;
    localparam int MAX_CHANNELS_DEF   = 8;
    localparam int WEIGHT_ENTRIES_DEF = 1024;

    localparam int SAMPLE_W   = 24;
    localparam int DELAY_W    = 14;
    localparam int CHAN_OUT_W = 3;
    localparam int WEIGHT_W   = 16;
    localparam int TOTAL_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_LENGTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 3'd4;

    localparam logic [1:0] WIDTH_CODE_16 = 2'd2;

    // Unity weight in Q1.15
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'h8000;

    // One transfer's worth of work for the back end
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       narrow;
        logic [WEIGHT_W-1:0]        weight;
        logic                       zero_a;
        logic                       byp_a;
        logic                       zero_b;
        logic                       byp_b;
        logic [CHAN_OUT_W-1:0]      channel;
        logic                       adjusting;
        logic [DELAY_W-1:0]         delay;
        logic [TOTAL_W-1:0]         total;
        logic                       rejected;
    } adl_meta_t;

endpackage

// File: rtl/core/adl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adl_front
// Accepts samples, keeps the delay and crossfade state, and issues one ring
// command per sample.
// ----------------------------------------------------------------------------
module adl_front
    import adl_pkg::*;
#(
    parameter int RING_FRAMES    = RING_FRAMES_DEF,
    parameter int MAX_CHANNELS   = MAX_CHANNELS_DEF,
    parameter int WEIGHT_ENTRIES = WEIGHT_ENTRIES_DEF,
    localparam int AW = $clog2(RING_FRAMES * MAX_CHANNELS)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       period_start,
    input  logic                       target_valid,
    input  logic [DELAY_W-1:0]         target_delay,
    input  logic                       fifo_full,
    output logic                       push,
    output adl_meta_t                  meta,
    output logic [AW-1:0]              wr_addr,
    output logic [AW-1:0]              rd_addr_a,
    output logic [AW-1:0]              rd_addr_b
);

    localparam int  FW    = $clog2(RING_FRAMES);
    localparam int  CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int  FILLW = $clog2(RING_FRAMES + 1);
    localparam int  EW    = $clog2(WEIGHT_ENTRIES);
    localparam int  EPW   = 16 + $clog2(WEIGHT_ENTRIES + 1);
    localparam real PI    = 3.14159265358979323846;
    localparam logic [WEIGHT_W-1:0] ROM_ZERO = '0;

    logic [3:0]  chan_count_reg;
    logic [1:0]  width_code_reg;
    logic [13:0] max_delay_reg;
    logic [11:0] fade_len_reg;
    logic [15:0] phase_step_reg;

    logic [FW-1:0]       wf_reg, wf_next;
    logic [FILLW-1:0]    fill_reg, fill_next;
    logic [CHW-1:0]      chcnt_reg, chcnt_next;
    logic [DELAY_W-1:0]  app_reg, app_next, req_reg, req_next;
    logic [DELAY_W-1:0]  src_reg, src_next, dst_reg, dst_next;
    logic                fade_reg, fade_next;
    logic [12:0]         idx_reg, idx_next;
    logic [16:0]         ph_reg, ph_next;
    logic [WEIGHT_W-1:0] fw_reg, fw_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [WEIGHT_W-1:0] rom_q_reg;

    logic [WEIGHT_W-1:0] rom_table [WEIGHT_ENTRIES];
    logic [EW-1:0]       rom_addr;
    logic                rom_load;

    logic [3:0]         chans;
    logic [CHW-1:0]     ch;
    logic               last;
    logic               req_ok;
    logic [DELAY_W-1:0] da;
    logic [17:0]        ph_sum;
    logic [EPW-1:0]     rom_prod;

    // Raised-cosine weights, worked out at elaboration
    for (genvar gi = 0; gi < WEIGHT_ENTRIES; gi++) begin : g_rom
        localparam real ANG = PI * gi / (2.0 * WEIGHT_ENTRIES);
        localparam real SV  = $sin(ANG);
        localparam int  WV  = $rtoi(32768.0 * SV * SV + 0.5);
        assign rom_table[gi] = WEIGHT_W'(WV);
    end

    function automatic logic [FW-1:0] back_frame(input logic [FW-1:0] wf,
                                                 input logic [DELAY_W-1:0] d);
        int diff;
        diff = int'(wf) - int'(d);
        if (diff < 0)
        begin
            diff = diff + RING_FRAMES;
        end
        return FW'(diff);
    endfunction

    function automatic logic [AW-1:0] ring_addr(input logic [FW-1:0] frame,
                                                input logic [CHW-1:0] chn);
        return AW'(int'(frame) * MAX_CHANNELS + int'(chn));
    endfunction

    assign in_stall = fifo_full;
    assign push     = in_valid && !fifo_full;

    always_comb
    begin
        chans = chan_count_reg;
        if (chan_count_reg == 4'd0)
        begin
            chans = 4'd1;
        end
        else if (int'(chan_count_reg) > MAX_CHANNELS)
        begin
            chans = 4'(MAX_CHANNELS);
        end
        ch   = (int'(chcnt_reg) >= int'(chans)) ? '0 : chcnt_reg;
        last = (int'(ch) + 1 >= int'(chans));

        // delay request
        req_ok   = target_valid && (target_delay <= max_delay_reg);
        req_next = req_ok ? target_delay : req_reg;
        app_next = (req_ok && fill_reg == '0 && !fade_reg) ? target_delay : app_reg;

        fill_next  = fill_reg;
        fade_next  = fade_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        idx_next   = idx_reg;
        ph_next    = ph_reg;
        fw_next    = fw_reg;
        total_next = total_reg;
        rom_load   = 1'b0;

        // frame start
        if (ch == '0)
        begin
            if (fill_reg < FILLW'(RING_FRAMES))
            begin
                fill_next = fill_reg + 1'b1;
            end
            if (period_start && !fade_reg && req_next != app_next)
            begin
                fade_next = 1'b1;
                src_next  = app_next;
                dst_next  = req_next;
                idx_next  = '0;
                ph_next   = '0;
                fw_next   = (fade_len_reg == '0) ? WEIGHT_ONE : ROM_ZERO;
                // table entry for phase zero, in case the frame is cut short
                rom_load  = 1'b1;
            end
            else if (fade_reg)
            begin
                fw_next = (idx_reg >= {1'b0, fade_len_reg} || ph_reg[16]) ?
                          WEIGHT_ONE : rom_q_reg;
            end
        end

        meta.sample  = (width_code_reg == WIDTH_CODE_16) ?
                       {{8{sample_in[15]}}, sample_in[15:0]} : sample_in;
        meta.narrow  = (width_code_reg == WIDTH_CODE_16);
        meta.weight  = fade_next ? fw_next : '0;
        da           = fade_next ? src_next : app_next;
        meta.zero_a  = int'(da) >= int'(fill_next);
        meta.byp_a   = (da == '0);
        meta.zero_b  = int'(dst_next) >= int'(fill_next);
        meta.byp_b   = (dst_next == '0);
        meta.channel = CHAN_OUT_W'(ch);
        meta.rejected = target_valid && !req_ok;

        wr_addr   = ring_addr(wf_reg, ch);
        rd_addr_a = ring_addr(back_frame(wf_reg, da), ch);
        rd_addr_b = ring_addr(back_frame(wf_reg, dst_next), ch);

        // frame end
        ph_sum     = 18'(ph_next) + 18'(phase_step_reg);
        wf_next    = wf_reg;
        chcnt_next = CHW'(int'(ch) + 1);
        if (last)
        begin
            if (fade_next)
            begin
                idx_next = idx_next + 1'b1;
                ph_next  = ph_sum[17] ? 17'h1FFFF : ph_sum[16:0];
                if (idx_next > {1'b0, fade_len_reg})
                begin
                    fade_next  = 1'b0;
                    app_next   = dst_next;
                    total_next = total_reg + 1'b1;
                end
                else
                begin
                    rom_load = 1'b1;
                end
            end
            wf_next    = (int'(wf_reg) == RING_FRAMES - 1) ? '0 : wf_reg + 1'b1;
            chcnt_next = '0;
        end

        rom_prod = EPW'(ph_next[15:0]) * EPW'(WEIGHT_ENTRIES);
        rom_addr = EW'(rom_prod >> 16);

        meta.adjusting = fade_next;
        meta.delay     = app_next;
        meta.total     = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_count_reg <= 4'd2;
            width_code_reg <= 2'd3;
            max_delay_reg  <= 14'd16383;
            fade_len_reg   <= 12'd480;
            phase_step_reg <= 16'd137;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CHANNEL_COUNT: chan_count_reg <= cfg_data[3:0];
                CFG_SAMPLE_WIDTH:  width_code_reg <= cfg_data[1:0];
                CFG_MAX_DELAY:     max_delay_reg  <= cfg_data[13:0];
                CFG_FADE_LENGTH:   fade_len_reg   <= cfg_data[11:0];
                CFG_PHASE_STEP:    phase_step_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wf_reg    <= '0;
            fill_reg  <= '0;
            chcnt_reg <= '0;
            app_reg   <= '0;
            req_reg   <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            fade_reg  <= 1'b0;
            idx_reg   <= '0;
            ph_reg    <= '0;
            fw_reg    <= '0;
            total_reg <= '0;
        end
        else if (push)
        begin
            wf_reg    <= wf_next;
            fill_reg  <= fill_next;
            chcnt_reg <= chcnt_next;
            app_reg   <= app_next;
            req_reg   <= req_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            fade_reg  <= fade_next;
            idx_reg   <= idx_next;
            ph_reg    <= ph_next;
            fw_reg    <= fw_next;
            total_reg <= total_next;
        end
    end

    // weight ROM, registered read for the next frame
    always_ff @(posedge clk)
    begin
        if (push && rom_load)
        begin
            rom_q_reg <= rom_table[rom_addr];
        end
    end

endmodule

// File: rtl/core/adl_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adl_fifo
// Two-entry command queue between front and back end.
// ----------------------------------------------------------------------------
module adl_fifo
    import adl_pkg::*;
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         full,
    output logic         avail,
    output logic [1:0]   level
);

    logic [W-1:0] mem_reg [2];
    logic         wptr_reg, rptr_reg;
    logic [1:0]   count_reg;

    assign dout  = mem_reg[rptr_reg];
    assign full  = (count_reg == 2'd2);
    assign avail = (count_reg != 2'd0);
    assign level = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= din;
        end
    end

endmodule

// File: rtl/core/adl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adl_back
// Ring memory, two reads per sample, blend, rounding, clipping and the
// output register.
// ----------------------------------------------------------------------------
module adl_back
    import adl_pkg::*;
#(
    parameter int RING_FRAMES  = RING_FRAMES_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    localparam int AW = $clog2(RING_FRAMES * MAX_CHANNELS)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       avail,
    input  adl_meta_t                  meta,
    input  logic [AW-1:0]              wr_addr,
    input  logic [AW-1:0]              rd_addr_a,
    input  logic [AW-1:0]              rd_addr_b,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic [CHAN_OUT_W-1:0]      out_channel,
    output logic                       adjusting,
    output logic [DELAY_W-1:0]         current_delay,
    output logic [TOTAL_W-1:0]         crossfade_total,
    output logic                       target_rejected
);

    localparam int DEPTH = RING_FRAMES * MAX_CHANNELS;

    logic signed [SAMPLE_W-1:0] ring_mem [DEPTH];
    logic signed [SAMPLE_W-1:0] mem_q_reg;

    logic        en;
    logic        phase_reg;
    logic        t1_valid_reg, t1_isb_reg, t2_valid_reg, out_valid_reg;
    adl_meta_t   iss_meta_reg, t1_meta_reg, t2_meta_reg;
    logic [AW-1:0] iss_rb_reg;
    logic signed [SAMPLE_W-1:0] a_reg, sel;
    logic signed [40:0] pa_reg, pb_reg;
    logic [WEIGHT_W-1:0] cw;
    logic signed [41:0] sum, rnd, top;

    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic [CHAN_OUT_W-1:0]      channel_reg;
    logic                       adjusting_reg, rejected_reg;
    logic [DELAY_W-1:0]         delay_reg;
    logic [TOTAL_W-1:0]         total_reg;

    assign en  = !out_valid_reg || !out_stall;
    assign pop = en && !phase_reg && avail;

    always_comb
    begin
        if (t1_isb_reg)
        begin
            sel = t1_meta_reg.zero_b ? '0 :
                  (t1_meta_reg.byp_b ? t1_meta_reg.sample : mem_q_reg);
        end
        else
        begin
            sel = t1_meta_reg.zero_a ? '0 :
                  (t1_meta_reg.byp_a ? t1_meta_reg.sample : mem_q_reg);
        end
        cw = WEIGHT_ONE - t1_meta_reg.weight;

        // round half away from zero, then clip to the active width
        sum = 42'(pa_reg) + 42'(pb_reg);
        if (sum >= 0)
        begin
            rnd = (sum + 42'sd16384) >>> 15;
        end
        else
        begin
            rnd = -((-sum + 42'sd16384) >>> 15);
        end
        top = t2_meta_reg.narrow ? 42'sd32767 : 42'sd8388607;
        if (rnd > top)
        begin
            rnd = top;
        end
        else if (rnd < -top - 42'sd1)
        begin
            rnd = -top - 42'sd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            t1_valid_reg  <= 1'b0;
            t1_isb_reg    <= 1'b0;
            t2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            if (pop)
            begin
                phase_reg    <= 1'b1;
                t1_valid_reg <= 1'b1;
                t1_isb_reg   <= 1'b0;
            end
            else if (phase_reg)
            begin
                phase_reg    <= 1'b0;
                t1_valid_reg <= 1'b1;
                t1_isb_reg   <= 1'b1;
            end
            else
            begin
                t1_valid_reg <= 1'b0;
            end
            t2_valid_reg  <= t1_valid_reg && t1_isb_reg;
            out_valid_reg <= t2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (pop)
            begin
                iss_meta_reg <= meta;
                iss_rb_reg   <= rd_addr_b;
                t1_meta_reg  <= meta;
            end
            else if (phase_reg)
            begin
                t1_meta_reg <= iss_meta_reg;
            end
            if (t1_valid_reg && !t1_isb_reg)
            begin
                a_reg <= sel;
            end
            if (t1_valid_reg && t1_isb_reg)
            begin
                pa_reg      <= a_reg * $signed({1'b0, cw});
                pb_reg      <= sel * $signed({1'b0, t1_meta_reg.weight});
                t2_meta_reg <= t1_meta_reg;
            end
            if (t2_valid_reg)
            begin
                sample_out_reg <= SAMPLE_W'(rnd);
                channel_reg    <= t2_meta_reg.channel;
                adjusting_reg  <= t2_meta_reg.adjusting;
                delay_reg      <= t2_meta_reg.delay;
                total_reg      <= t2_meta_reg.total;
                rejected_reg   <= t2_meta_reg.rejected;
            end
        end
    end

    // ring memory: at most one write and one read a cycle, none while the output is stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (pop)
            begin
                ring_mem[wr_addr] <= meta.sample;
            end
            mem_q_reg <= ring_mem[phase_reg ? iss_rb_reg : rd_addr_a];
        end
    end

    assign out_valid       = out_valid_reg;
    assign sample_out      = sample_out_reg;
    assign out_channel     = channel_reg;
    assign adjusting       = adjusting_reg;
    assign current_delay   = delay_reg;
    assign crossfade_total = total_reg;
    assign target_rejected = rejected_reg;

endmodule

// File: rtl/core/audio_delay_line_crossfade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_delay_line_crossfade
// Variable delay line for interleaved audio with a raised-cosine crossfade
// between the old and the new delay.
// ----------------------------------------------------------------------------
//
//  channel | signals                                          | transfer when
//  --------+--------------------------------------------------+------------------
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data           | valid && ready
//  in      | in_valid in_stall sample_in period_start          | valid && !stall
//          | target_valid target_delay                        |
//  out     | out_valid out_stall sample_out out_channel        | valid && !stall
//          | adjusting current_delay crossfade_total           |
//          | target_rejected                                  |
//
//  Each sample takes the single ring memory port pair twice (write plus
//  old-delay read, then new-delay read); the next sample waits for both.
//  A sample passes the queue, both reads, the products and the output register.
//  Reset clears all control state; the ring needs no clearing, as reads
//  beyond the frames written so far are forced to zero.
//  The two-entry queue lets the front take samples while the back end is
//  held by out_stall; cfg_ready is always high.
// ----------------------------------------------------------------------------
module audio_delay_line_crossfade
    import adl_pkg::*;
#(
    parameter int RING_FRAMES    = RING_FRAMES_DEF,
    parameter int MAX_CHANNELS   = MAX_CHANNELS_DEF,
    parameter int WEIGHT_ENTRIES = WEIGHT_ENTRIES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       period_start,
    input  logic                       target_valid,
    input  logic [DELAY_W-1:0]         target_delay,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic [CHAN_OUT_W-1:0]      out_channel,
    output logic                       adjusting,
    output logic [DELAY_W-1:0]         current_delay,
    output logic [TOTAL_W-1:0]         crossfade_total,
    output logic                       target_rejected
);

    localparam int AW = $clog2(RING_FRAMES * MAX_CHANNELS);
    localparam int MW = $bits(adl_meta_t);
    localparam int QW = MW + 3 * AW;

    logic          push, pop, fifo_full, fifo_avail;
    logic [1:0]    fifo_level;
    adl_meta_t     push_meta, pop_meta;
    logic [AW-1:0] push_wr, push_ra, push_rb, pop_wr, pop_ra, pop_rb;
    logic [QW-1:0] q_din, q_dout;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    adl_front #(
        .RING_FRAMES    (RING_FRAMES),
        .MAX_CHANNELS   (MAX_CHANNELS),
        .WEIGHT_ENTRIES (WEIGHT_ENTRIES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_in    (sample_in),
        .period_start (period_start),
        .target_valid (target_valid),
        .target_delay (target_delay),
        .fifo_full    (fifo_full),
        .push         (push),
        .meta         (push_meta),
        .wr_addr      (push_wr),
        .rd_addr_a    (push_ra),
        .rd_addr_b    (push_rb)
    );

    // command word: record plus the three ring addresses
    assign q_din = {push_meta, push_wr, push_ra, push_rb};
    assign pop_meta = q_dout[QW-1 -: MW];
    assign pop_wr   = q_dout[3*AW-1 -: AW];
    assign pop_ra   = q_dout[2*AW-1 -: AW];
    assign pop_rb   = q_dout[AW-1:0];

    adl_fifo #(
        .W (QW)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (q_din),
        .pop   (pop),
        .dout  (q_dout),
        .full  (fifo_full),
        .avail (fifo_avail),
        .level (fifo_level)
    );

    adl_back #(
        .RING_FRAMES  (RING_FRAMES),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .avail           (fifo_avail),
        .meta            (pop_meta),
        .wr_addr         (pop_wr),
        .rd_addr_a       (pop_ra),
        .rd_addr_b       (pop_rb),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .sample_out      (sample_out),
        .out_channel     (out_channel),
        .adjusting       (adjusting),
        .current_delay   (current_delay),
        .crossfade_total (crossfade_total),
        .target_rejected (target_rejected)
    );

`ifndef SYNTH
    // queue never holds more than its two entries
    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_level <= 2'd2)
        else $error("command queue level out of range");

    // blend weight never exceeds unity
    a_weight: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_meta.weight <= WEIGHT_ONE)
        else $error("crossfade weight above unity");

    // a rejection is only flagged for a sample that carries a request
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_meta.rejected |-> target_valid)
        else $error("rejection without a request");
`endif

endmodule
